/* src/dht_pkg.sv */
package dht_pkg;

   localparam int NUM_LINES = 4;
   localparam int LINE_W    = 2;
   localparam int BIT_TOTAL = 40;
   localparam int IDX_W     = 6;
   localparam int CNT_W     = 16;

   localparam logic [15:0] START_LOW_RESET    = 16'd20000;
   localparam logic [7:0]  RELEASE_HIGH_RESET = 8'd10;
   localparam logic [7:0]  RESPONSE_RESET     = 8'd100;
   localparam logic [7:0]  BIT_TIMEOUT_RESET  = 8'd101;
   localparam logic [7:0]  ONE_THRESH_RESET   = 8'd51;

   // register indexes on the csr port
   localparam logic [2:0] REG_START_LOW    = 3'd0;
   localparam logic [2:0] REG_RELEASE_HIGH = 3'd1;
   localparam logic [2:0] REG_RESPONSE     = 3'd2;
   localparam logic [2:0] REG_BIT_TIMEOUT  = 3'd3;
   localparam logic [2:0] REG_ONE_THRESH   = 3'd4;

   // line drive codes
   localparam logic [1:0] DRV_RELEASE = 2'd0;
   localparam logic [1:0] DRV_LOW     = 2'd1;
   localparam logic [1:0] DRV_HIGH    = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK           = 2'd0;
   localparam logic [1:0] ST_RESP_TIMEOUT = 2'd1;
   localparam logic [1:0] ST_BIT_TIMEOUT  = 2'd2;
   localparam logic [1:0] ST_CHECKSUM     = 2'd3;

   typedef enum logic [6:0] {
      PH_IDLE       = 7'b0000001,
      PH_START_LOW  = 7'b0000010,
      PH_START_HIGH = 7'b0000100,
      PH_RESP_LOW   = 7'b0001000,
      PH_RESP_HIGH  = 7'b0010000,
      PH_BIT_LOW    = 7'b0100000,
      PH_BIT_HIGH   = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic [15:0] start_low_ticks;
      logic [7:0]  release_high_ticks;
      logic [7:0]  response_limit;
      logic [7:0]  bit_timeout;
      logic [7:0]  one_threshold;
   } cfg_type;

   typedef struct packed {
      logic        start_request;
      logic [1:0]  line_select;
      logic [3:0]  line_levels;
   } item_type;

   typedef struct packed {
      logic [1:0]  line_drive;
      logic [1:0]  active_line;
      logic        busy_res;
      logic        done_res;
      logic [1:0]  status;
      logic [7:0]  humidity;
      logic [7:0]  temperature;
   } result_type;

endpackage

/* src/dht_csr.sv */
module dht_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  logic [2:0]         wr_index,
   input  logic [15:0]        wr_data,
   output dht_pkg::cfg_type   cfg
);
   import dht_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            REG_START_LOW:    cfg_in.start_low_ticks    = wr_data;
            REG_RELEASE_HIGH: cfg_in.release_high_ticks = wr_data[7:0];
            REG_RESPONSE:     cfg_in.response_limit     = wr_data[7:0];
            REG_BIT_TIMEOUT:  cfg_in.bit_timeout        = wr_data[7:0];
            REG_ONE_THRESH:   cfg_in.one_threshold      = wr_data[7:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_low_ticks    <= START_LOW_RESET;
         cfg_ff.release_high_ticks <= RELEASE_HIGH_RESET;
         cfg_ff.response_limit     <= RESPONSE_RESET;
         cfg_ff.bit_timeout        <= BIT_TIMEOUT_RESET;
         cfg_ff.one_threshold      <= ONE_THRESH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* src/dht_core.sv */
module dht_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  dht_pkg::item_type    item,
   input  dht_pkg::cfg_type     cfg,
   output dht_pkg::result_type  result
);
   import dht_pkg::*;

   phase_type         phase_ff, phase_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  bit_index_ff, bit_index_in;
   logic [39:0]       bits_ff, bits_in;
   logic [LINE_W-1:0] line_ff, line_in;
   logic [7:0]        hum_ff, hum_in;
   logic [7:0]        temp_ff, temp_in;

   logic              level;
   logic [CNT_W-1:0]  count_up;
   logic [39:0]       shifted;
   logic [IDX_W-1:0]  idx_next;
   logic [7:0]        byte_sum;
   logic              done;
   logic [1:0]        status;

   // lines beyond the fitted count read low
   assign level = (32'(line_ff) < NUM_LINES) ? item.line_levels[line_ff] : 1'b0;
   assign count_up = (count_ff == {CNT_W{1'b1}}) ? count_ff : count_ff + 1'b1;
   assign shifted  = {bits_ff[38:0], (count_ff >= {8'd0, cfg.one_threshold})};
   assign idx_next = bit_index_ff + 1'b1;
   assign byte_sum = shifted[39:32] + shifted[31:24] + shifted[23:16] + shifted[15:8];

   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      bit_index_in = bit_index_ff;
      bits_in      = bits_ff;
      line_in      = line_ff;
      hum_in       = hum_ff;
      temp_in      = temp_ff;
      done         = 1'b0;
      status       = ST_OK;
      unique case (phase_ff)
         PH_IDLE: begin
            if (item.start_request) begin
               line_in  = item.line_select;
               phase_in = PH_START_LOW;
               count_in = CNT_W'(1);
            end
         end
         PH_START_LOW: begin
            if (count_ff >= cfg.start_low_ticks) begin
               phase_in = PH_START_HIGH;
               count_in = CNT_W'(1);
            end else begin
               count_in = count_up;
            end
         end
         PH_START_HIGH: begin
            if (count_ff >= {8'd0, cfg.release_high_ticks}) begin
               phase_in = PH_RESP_LOW;
               count_in = '0;
            end else begin
               count_in = count_up;
            end
         end
         PH_RESP_LOW, PH_RESP_HIGH: begin
            if (level == (phase_ff == PH_RESP_LOW)) begin
               count_in = '0;
               if (phase_ff == PH_RESP_LOW) begin
                  phase_in = PH_RESP_HIGH;
               end else begin
                  phase_in     = PH_BIT_LOW;
                  bit_index_in = '0;
                  bits_in      = '0;
               end
            end else if (count_up >= {8'd0, cfg.response_limit}) begin
               phase_in = PH_IDLE;
               count_in = '0;
               done     = 1'b1;
               status   = ST_RESP_TIMEOUT;
            end else begin
               count_in = count_up;
            end
         end
         PH_BIT_LOW: begin
            if (level) begin
               phase_in = PH_BIT_HIGH;
               count_in = '0;
            end else if (count_up >= {8'd0, cfg.bit_timeout}) begin
               phase_in = PH_IDLE;
               count_in = '0;
               done     = 1'b1;
               status   = ST_BIT_TIMEOUT;
            end else begin
               count_in = count_up;
            end
         end
         PH_BIT_HIGH: begin
            if (!level) begin
               bits_in      = shifted;
               bit_index_in = idx_next;
               count_in     = '0;
               if (32'(idx_next) >= BIT_TOTAL) begin
                  phase_in = PH_IDLE;
                  done     = 1'b1;
                  if (byte_sum == shifted[7:0]) begin
                     hum_in  = shifted[39:32];
                     temp_in = shifted[23:16];
                     status  = ST_OK;
                  end else begin
                     status  = ST_CHECKSUM;
                  end
               end else begin
                  phase_in = PH_BIT_LOW;
               end
            end else if (count_up >= {8'd0, cfg.bit_timeout}) begin
               phase_in = PH_IDLE;
               count_in = '0;
               done     = 1'b1;
               status   = ST_BIT_TIMEOUT;
            end else begin
               count_in = count_up;
            end
         end
         default: begin
            phase_in = PH_IDLE;
            count_in = '0;
         end
      endcase
   end

   always_comb begin
      result.line_drive  = (phase_in == PH_START_LOW)  ? DRV_LOW  :
                           (phase_in == PH_START_HIGH) ? DRV_HIGH : DRV_RELEASE;
      result.active_line = line_in;
      result.busy_res    = (phase_in != PH_IDLE);
      result.done_res    = done;
      result.status      = done ? status : ST_OK;
      result.humidity    = hum_in;
      result.temperature = temp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         count_ff     <= '0;
         bit_index_ff <= '0;
         bits_ff      <= '0;
         line_ff      <= '0;
         hum_ff       <= '0;
         temp_ff      <= '0;
      end else if (step_en) begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         bit_index_ff <= bit_index_in;
         bits_ff      <= bits_in;
         line_ff      <= line_in;
         hum_ff       <= hum_in;
         temp_ff      <= temp_in;
      end
   end

   a_done_goes_idle: assert property (@(posedge clock) disable iff (reset)
      step_en && done |=> phase_ff == PH_IDLE)
      else $error("finished reading did not return to idle");

   a_idle_no_start: assert property (@(posedge clock) disable iff (reset)
      step_en && phase_ff == PH_IDLE && !item.start_request |-> !result.busy_res)
      else $error("busy without a start request");

   a_drive_busy: assert property (@(posedge clock) disable iff (reset)
      step_en && result.line_drive != DRV_RELEASE |-> result.busy_res)
      else $error("line driven while not busy");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      32'(bit_index_ff) <= BIT_TOTAL)
      else $error("bit index past frame length");

endmodule

/* src/dht11_single_wire_reader_unit.sv */
// single-wire humidity/temperature sensor reader, one beat per microsecond tick
//
// req channel: one beat per tick, carrying the start request, the line select
//   and the sampled levels of the four sensor lines
// rsp channel: exactly one beat per req beat, in order, giving the line drive,
//   the active line, busy/done flags, status and the last good humidity and
//   temperature bytes, all as they stand after that tick
// csr channel: register writes (index 0..4), always ready, meant for idle only;
//   writes to unused indexes are dropped
//
// path: a req beat is registered in the input register, stepped through the
//   sequencer once the rsp register is free or being emptied, and lands in the
//   rsp register, where its rsp beat is then visible
// throughput: one beat per cycle while rsp is not held, one sequencer step per beat
// reset: sequencer idle, counters and stored readings cleared, registers back to
//   their defaults, both channel registers empty
// stall: while rsp is held the input register keeps one pending beat, then
//   req_tready drops; no beat is lost or repeated
module dht11_single_wire_reader_unit (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: start_request[0], line_select[2:1], line_levels[6:3], zero[7]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   // rsp_tdata: line_drive[1:0], active_line[3:2], busy_res[4], done_res[5],
   //            status[7:6], humidity[15:8], temperature[23:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   import dht_pkg::*;

   // input stage
   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff;

   // output stage
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;

   logic       advance;
   cfg_type    cfg;
   result_type step_result;
   item_type   req_item;

   assign req_item.start_request = req_tdata[0];
   assign req_item.line_select   = req_tdata[2:1];
   assign req_item.line_levels   = req_tdata[6:3];

   // step the held tick whenever the result register is free or being emptied
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   dht_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   dht_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_data_ff.temperature, rsp_data_ff.humidity,
                        rsp_data_ff.status, rsp_data_ff.done_res,
                        rsp_data_ff.busy_res, rsp_data_ff.active_line,
                        rsp_data_ff.line_drive};

   a_step_needs_item: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("stepped tick produced no response beat");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && rsp_valid_ff && !rsp_tready |-> !req_tready)
      else $error("input taken while both stages are full");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.done_res |-> !rsp_data_ff.busy_res)
      else $error("finished reading still flagged busy");

endmodule
